// ===== src/sfb_pkg.sv =====
// sfb_pkg: shared types and constants for the sum16 frame builder
// used by sfb_front, sfb_queue, sfb_back and sum16_frame_builder
package sfb_pkg;

   localparam int MAX_PAYLOAD_DEF = 128;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // operation codes on the request side
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // frame constants
   localparam logic [7:0] HDR_SYNC0 = 8'hA6;
   localparam logic [7:0] HDR_SYNC1 = 8'h59;
   localparam logic [7:0] HDR_REG   = 8'h01;
   localparam logic [7:0] TAIL_Y    = 8'h59;
   localparam logic [7:0] TAIL_H    = 8'h48;
   localparam logic [7:0] TAIL_T    = 8'h54;
   localparam logic [7:0] LEN_EXTRA = 8'd11;

   // register indexes
   localparam logic [1:0] REG_UNIT_ID        = 2'd0;
   localparam logic [1:0] REG_COMMAND_ID     = 2'd1;
   localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd2;

   // back-end byte positions
   localparam logic [3:0] STEP_FIRST  = 4'd0;
   localparam logic [3:0] STEP_SYNC1  = 4'd1;
   localparam logic [3:0] STEP_LEN    = 4'd2;
   localparam logic [3:0] STEP_DEV    = 4'd3;
   localparam logic [3:0] STEP_CMD    = 4'd4;
   localparam logic [3:0] STEP_REG    = 4'd5;
   localparam logic [3:0] STEP_SUM_HI = 4'd6;
   localparam logic [3:0] STEP_SUM_LO = 4'd7;
   localparam logic [3:0] STEP_Y      = 4'd8;
   localparam logic [3:0] STEP_H      = 4'd9;
   localparam logic [3:0] STEP_T      = 4'd10;

   // one classified job between front and back
   typedef struct packed {
      logic       is_start;   // header job, else one payload byte
      logic       close;      // tail follows this job
      logic [7:0] data;       // payload byte, or length byte for a start
      logic [7:0] unit_id;
      logic [7:0] command_id;
   } job_type;

endpackage

// ===== src/sfb_front.sv =====
// sfb_front: accepts request words, tracks the open frame and classifies jobs
// depends on sfb_pkg
module sfb_front
   import sfb_pkg::*;
#(
   parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic       req_tuser,     // [0] operation
   input  logic [7:0] unit_id,
   input  logic [7:0] command_id,
   input  logic [7:0] payload_length,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   localparam logic [7:0] MaxLen = 8'(MaxPayload);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] len_eff;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign len_eff    = (payload_length > MaxLen) ? MaxLen : payload_length;

   always_comb begin
      in_frame_in        = in_frame_ff;
      left_in            = left_ff;
      q_push             = 1'b0;
      q_job.is_start     = 1'b0;
      q_job.close        = 1'b0;
      q_job.data         = req_tdata;
      q_job.unit_id      = unit_id;
      q_job.command_id   = command_id;
      if (accept) begin
         if (req_tuser == OP_START) begin
            q_push         = 1'b1;
            q_job.is_start = 1'b1;
            q_job.close    = (len_eff == 8'd0);
            q_job.data     = len_eff + LEN_EXTRA;
            in_frame_in    = (len_eff != 8'd0);
            left_in        = len_eff;
         end else if (in_frame_ff) begin
            // stray payload outside a frame is dropped
            q_push      = 1'b1;
            q_job.close = (left_ff <= 8'd1);
            left_in     = (left_ff == 8'd0) ? 8'd0 : left_ff - 8'd1;
            if (left_ff <= 8'd1) begin
               in_frame_in = 1'b0;
               left_in     = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         left_ff     <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         left_ff     <= left_in;
      end
   end

endmodule

// ===== src/sfb_queue.sv =====
// sfb_queue: small job fifo between front and back ends
// depends on sfb_pkg
module sfb_queue
   import sfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/sfb_back.sv =====
// sfb_back: sequences header, payload and tail bytes and keeps the checksum
// depends on sfb_pkg
module sfb_back
   import sfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast     // frame_end
);

   logic [3:0]  step_ff, step_in;
   logic [15:0] sum_ff, sum_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        advance;
   logic [7:0]  cur_byte;
   logic        cur_last;
   logic [15:0] sum_base;

   assign advance    = !q_empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      cur_last = 1'b0;
      case (step_ff)
         STEP_FIRST:  cur_byte = head_job.is_start ? HDR_SYNC0 : head_job.data;
         STEP_SYNC1:  cur_byte = HDR_SYNC1;
         STEP_LEN:    cur_byte = head_job.data;
         STEP_DEV:    cur_byte = head_job.unit_id;
         STEP_CMD:    cur_byte = head_job.command_id;
         STEP_REG:    cur_byte = HDR_REG;
         STEP_SUM_HI: cur_byte = sum_ff[15:8];
         STEP_SUM_LO: cur_byte = sum_ff[7:0];
         STEP_Y:      cur_byte = TAIL_Y;
         STEP_H:      cur_byte = TAIL_H;
         STEP_T: begin
            cur_byte = TAIL_T;
            cur_last = 1'b1;
         end
         default:     cur_byte = 8'd0;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      q_pop    = 1'b0;
      // a start job clears the sum on its first byte
      sum_base = (step_ff == STEP_FIRST && head_job.is_start) ? 16'd0 : sum_ff;
      sum_in   = sum_ff;
      if (advance) begin
         if (step_ff < STEP_SUM_HI) begin
            sum_in = sum_base + {8'd0, cur_byte};
         end
         case (step_ff)
            STEP_FIRST: begin
               if (head_job.is_start) begin
                  step_in = STEP_SYNC1;
               end else if (head_job.close) begin
                  step_in = STEP_SUM_HI;
               end else begin
                  q_pop = 1'b1;
               end
            end
            STEP_REG: begin
               if (head_job.close) begin
                  step_in = STEP_SUM_HI;
               end else begin
                  step_in = STEP_FIRST;
                  q_pop   = 1'b1;
               end
            end
            STEP_T: begin
               step_in = STEP_FIRST;
               q_pop   = 1'b1;
            end
            default: step_in = step_ff + 4'd1;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = cur_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_FIRST;
         sum_ff   <= 16'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   a_last_is_t: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (byte_ff == TAIL_T))
      else $error("frame end not on tail byte");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_T)
      else $error("step counter out of range");

   a_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (step_ff == STEP_FIRST))
      else $error("job popped mid sequence");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !valid_ff)
      else $error("output valid after reset");

endmodule

// ===== src/sum16_frame_builder.sv =====
// sum16_frame_builder: top level, csr registers plus front, queue and back ends
// depends on sfb_pkg, sfb_front, sfb_queue, sfb_back
// a job's first byte reaches rsp via a queue slot and the output byte register
// throughput: one payload byte per cycle while rsp is ready; a start job sends
// the header bytes, then checksum and tail for an empty frame; a closing payload
// byte adds both; the byte sequencer sets the rate; a 4-entry job queue decouples
// reset clears frame state, the queue and output valid; registers reload defaults
module sum16_frame_builder
   import sfb_pkg::*;
#(
   parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // frame_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] unit_id_ff, command_id_ff, payload_length_ff;
   logic       csr_wr;
   logic       q_push, q_pop, q_empty, q_full;
   job_type    push_job, head_job;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff        <= 8'd2;
         command_id_ff     <= 8'd1;
         payload_length_ff <= 8'd36;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_UNIT_ID:        unit_id_ff        <= csr_pwdata[7:0];
            REG_COMMAND_ID:     command_id_ff     <= csr_pwdata[7:0];
            REG_PAYLOAD_LENGTH: payload_length_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_UNIT_ID:        csr_prdata = {24'd0, unit_id_ff};
         REG_COMMAND_ID:     csr_prdata = {24'd0, command_id_ff};
         REG_PAYLOAD_LENGTH: csr_prdata = {24'd0, payload_length_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   sfb_front #(
      .MaxPayload (MaxPayload)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .unit_id        (unit_id_ff),
      .command_id     (command_id_ff),
      .payload_length (payload_length_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   sfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   sfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
